>>> src/awms_pkg.sv
package awms_pkg;

   // Width of the elapsed and read-timeout counters (8 to 32).
   localparam int TimerBits = 16;
   localparam int CfgTickBits = 16;
   localparam int BattBits = 10;
   localparam int CmpBits = (TimerBits > CfgTickBits) ? TimerBits : CfgTickBits;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits = 16;

   typedef logic [TimerBits-1:0] timer_type;
   typedef logic [CfgTickBits-1:0] cfg_tick_type;
   typedef logic [BattBits-1:0] batt_type;

   typedef enum logic [3:0] {
      MODE_START   = 4'd0,
      MODE_USER    = 4'd1,
      MODE_BATT    = 4'd2,
      MODE_LOWBAT  = 4'd3,
      MODE_CAL     = 4'd4,
      MODE_DETECT  = 4'd5,
      MODE_IMUERR  = 4'd6,
      MODE_INFLATE = 4'd7,
      MODE_HOLD    = 4'd8,
      MODE_INFERR  = 4'd9,
      MODE_DEFLATE = 4'd10
   } mode_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_CALIBRATION  = 3'd0,
      CSR_READ_TIMEOUT = 3'd1,
      CSR_INFLATE      = 3'd2,
      CSR_HOLD         = 3'd3,
      CSR_ERROR        = 3'd4,
      CSR_BATT_LOW     = 3'd5
   } csr_index_type;

   localparam cfg_tick_type CalibrationReset = 16'd5000;
   localparam cfg_tick_type ReadTimeoutReset = 16'd20;
   localparam cfg_tick_type InflateReset = 16'd80;
   localparam cfg_tick_type HoldReset = 16'd10000;
   localparam cfg_tick_type ErrorReset = 16'd10000;
   localparam batt_type BattLowReset = 10'd512;

   typedef struct packed {
      cfg_tick_type calibration_ticks;
      cfg_tick_type read_timeout_ticks;
      cfg_tick_type inflate_ticks;
      cfg_tick_type hold_ticks;
      cfg_tick_type error_ticks;
      batt_type     battery_low_threshold;
   } cfg_type;

   typedef struct packed {
      logic       user_present;
      logic       imu_init_ok;
      batt_type   battery_level;
      logic       data_read_ok;
      logic [3:0] fall_direction;
      logic       pressure_ok;
   } req_type;

   typedef struct packed {
      logic [3:0] mode;
      logic       user_led;
      logic       fall_led;
      logic       inflated_led;
      logic       inflate_pulse;
      logic       deflate_pulse;
      logic       shutdown_pulse;
      logic       error_lights;
   } rsp_type;

   function automatic timer_type sat_inc(timer_type v);
      return (v == '1) ? v : timer_type'(v + 1'b1);
   endfunction

   function automatic logic timer_reached(timer_type cnt, cfg_tick_type lim);
      return CmpBits'(cnt) >= CmpBits'(lim);
   endfunction

endpackage

>>> src/awms_csr.sv
module awms_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [awms_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [awms_pkg::CsrDataBits-1:0]  csr_wdata,
   output awms_pkg::cfg_type                 cfg
);
   import awms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CALIBRATION:  cfg_in.calibration_ticks = cfg_tick_type'(csr_wdata);
            CSR_READ_TIMEOUT: cfg_in.read_timeout_ticks = cfg_tick_type'(csr_wdata);
            CSR_INFLATE:      cfg_in.inflate_ticks = cfg_tick_type'(csr_wdata);
            CSR_HOLD:         cfg_in.hold_ticks = cfg_tick_type'(csr_wdata);
            CSR_ERROR:        cfg_in.error_ticks = cfg_tick_type'(csr_wdata);
            CSR_BATT_LOW:     cfg_in.battery_low_threshold = csr_wdata[BattBits-1:0];
            default:          ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calibration_ticks     <= CalibrationReset;
         cfg_ff.read_timeout_ticks    <= ReadTimeoutReset;
         cfg_ff.inflate_ticks         <= InflateReset;
         cfg_ff.hold_ticks            <= HoldReset;
         cfg_ff.error_ticks           <= ErrorReset;
         cfg_ff.battery_low_threshold <= BattLowReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/awms_seq.sv
module awms_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  awms_pkg::req_type req,
   input  awms_pkg::cfg_type cfg,
   output awms_pkg::rsp_type rsp
);
   import awms_pkg::*;

   mode_type  mode_ff, mode_in;
   timer_type elapsed_ff, elapsed_in;
   timer_type since_read_ff, since_read_in;
   logic [2:0] led_ff, led_in;   // bit0 user, bit1 fall, bit2 inflated
   logic low_batt;
   logic fall;
   logic inflate_p, deflate_p, shutdown_p;

   always_comb begin
      low_batt      = req.battery_level < cfg.battery_low_threshold;
      fall          = |req.fall_direction;
      mode_in       = mode_ff;
      elapsed_in    = sat_inc(elapsed_ff);
      since_read_in = sat_inc(since_read_ff);
      led_in        = led_ff;
      inflate_p     = 1'b0;
      deflate_p     = 1'b0;
      shutdown_p    = 1'b0;

      unique case (mode_ff)
         MODE_START: begin
            mode_in = MODE_USER;
         end
         MODE_USER: begin
            if (req.user_present) begin
               led_in[0] = 1'b1;
               if (!req.imu_init_ok) begin
                  mode_in    = MODE_IMUERR;
                  elapsed_in = '0;
               end else begin
                  mode_in = MODE_BATT;
               end
            end
         end
         MODE_BATT: begin
            if (low_batt) begin
               mode_in = MODE_LOWBAT;
            end else begin
               mode_in    = MODE_CAL;
               elapsed_in = '0;
            end
         end
         MODE_LOWBAT: begin
            // inverted test kept: a low sample here shuts down
            if (low_batt) begin
               shutdown_p = 1'b1;
               mode_in    = MODE_START;
            end
         end
         MODE_CAL: begin
            priority if (!req.user_present) begin
               led_in[0]  = 1'b0;
               shutdown_p = 1'b1;
               mode_in    = MODE_START;
            end else if (low_batt) begin
               mode_in = MODE_LOWBAT;
            end else if (timer_reached(elapsed_in, cfg.calibration_ticks)) begin
               mode_in = MODE_DETECT;
            end else begin
               mode_in = MODE_CAL;
            end
         end
         MODE_DETECT: begin
            priority if (!req.user_present) begin
               led_in[0]  = 1'b0;
               shutdown_p = 1'b1;
               mode_in    = MODE_START;
            end else if (low_batt) begin
               mode_in = MODE_LOWBAT;
            end else if (!req.data_read_ok) begin
               if (timer_reached(since_read_in, cfg.read_timeout_ticks)) begin
                  mode_in    = MODE_IMUERR;
                  elapsed_in = '0;
               end
            end else begin
               since_read_in = '0;
               if (fall) begin
                  led_in[1]  = 1'b1;
                  inflate_p  = 1'b1;
                  mode_in    = MODE_INFLATE;
                  elapsed_in = '0;
               end
            end
         end
         MODE_IMUERR, MODE_INFERR: begin
            if (timer_reached(elapsed_in, cfg.error_ticks)) begin
               shutdown_p = 1'b1;
               elapsed_in = '0;
            end
         end
         MODE_INFLATE: begin
            if (timer_reached(elapsed_in, cfg.inflate_ticks)) begin
               led_in[1]  = 1'b0;
               led_in[2]  = 1'b1;
               elapsed_in = '0;
               mode_in    = MODE_HOLD;
            end
         end
         MODE_HOLD: begin
            priority if (!req.pressure_ok) begin
               mode_in    = MODE_INFERR;
               elapsed_in = '0;
            end else if (timer_reached(elapsed_in, cfg.hold_ticks)) begin
               led_in[2]  = 1'b0;
               elapsed_in = '0;
               mode_in    = MODE_DEFLATE;
            end else begin
               mode_in = MODE_HOLD;
            end
         end
         MODE_DEFLATE: begin
            // elapsed keeps running, so calibration counts from deflate entry
            deflate_p = 1'b1;
            mode_in   = MODE_CAL;
         end
         default: begin
            mode_in = MODE_START;
         end
      endcase

      rsp.mode           = mode_in;
      rsp.user_led       = led_in[0];
      rsp.fall_led       = led_in[1];
      rsp.inflated_led   = led_in[2];
      rsp.inflate_pulse  = inflate_p;
      rsp.deflate_pulse  = deflate_p;
      rsp.shutdown_pulse = shutdown_p;
      rsp.error_lights   = (mode_in == MODE_IMUERR) || (mode_in == MODE_INFERR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_START;
         elapsed_ff    <= '0;
         since_read_ff <= '0;
         led_ff        <= '0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         elapsed_ff    <= elapsed_in;
         since_read_ff <= since_read_in;
         led_ff        <= led_in;
      end
   end

endmodule

>>> src/airbag_wearable_mode_sequencer.sv
// Channel  | Ports                              | Beat
// ---------+------------------------------------+----------------------------------
// request  | req_valid, req_ready, req_data     | one millisecond tick of inputs
// response | rsp_valid, rsp_ready, rsp_data     | mode, LEDs and pulses after tick
// config   | csr_wr_en, csr_index, csr_wdata    | one register write, no wait
//
// A request beat lands in the input register; when the output register is free
// or draining, the sequencer step runs in one pass and its result lands in the
// output register. One beat per cycle while the receiver does not stall.
// Throughput is set by the single output register: the step fires whenever
// the output register is empty or being drained in the same cycle.
// Synchronous active-high reset clears both valid flags, the mode, the two
// counters, the LEDs and restores the register defaults.
module airbag_wearable_mode_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  awms_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output awms_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [awms_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [awms_pkg::CsrDataBits-1:0]  csr_wdata
);
   import awms_pkg::*;

   cfg_type cfg;
   req_type in_ff;
   logic    in_valid_ff;
   rsp_type out_ff;
   logic    out_valid_ff;
   rsp_type step_rsp;
   logic    advance;

   // Advance the held tick whenever the output slot is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   awms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   awms_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // Input register: hold the beat until the step consumes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // Output register: load on each step, drop valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> tb/tb_airbag_wearable_mode_sequencer.sv
`timescale 1ns / 1ps

module tb_airbag_wearable_mode_sequencer;

   import awms_pkg::*;

   // Quiet cycles (no beat on either channel) before the run is declared hung.
   localparam int StallLimit = 1000;
   // Cycles to hold after the last status beat before touching registers.
   localparam int SettleCycles = 4;
   localparam int PhaseCount = 6;
   localparam int DirCount = 25;

   // Register slots past the last real one; writes there must be dropped.
   localparam logic [CsrIndexBits-1:0] CsrSpareLo = 3'd6;
   localparam logic [CsrIndexBits-1:0] CsrSpareHi = 3'd7;

   // Stimulus guards: each bit keeps one route into an error state closed.
   localparam int GuardImu = 0;
   localparam int GuardRead = 1;
   localparam int GuardPress = 2;
   localparam logic [2:0] GuardAll = 3'b111;

   // Directed table column codes.
   localparam logic KeepCfg = 1'b0;
   localparam logic LoadShort = 1'b1;
   localparam logic Predict = 1'b0;
   localparam logic Typed = 1'b1;

   typedef struct packed {
      logic    load_short;  // drain and load the short directed timings first
      logic    typed;       // use the status typed in the row, not the predictor
      rsp_type want;
      req_type tick;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic                    csr_wr_en = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   // Status the tick now on req_data should produce; travels with the beat.
   rsp_type pending_status = '0;
   rsp_type expected_status[$];
   rsp_type oldest_status;

   int ticks_launched = 0;
   int status_seen = 0;
   int fault_count = 0;

   // Receiver stall state.
   int rx_hold = 0;
   bit rx_steady = 1'b0;

   // Sequencer shadow: register copy and state, advanced once per tick launched.
   cfg_type   cfg;
   mode_type  cur_mode;
   timer_type elapsed;
   timer_type since_read;
   logic      led_user;
   logic      led_fall;
   logic      led_full;

   dir_row_type dir_rows [DirCount];

   airbag_wearable_mode_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long; zero in steady stretches.
   function automatic int pick_gap(input bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic req_type tick_of(input logic u, input logic imu, input int unsigned batt,
                                       input logic rd, input logic [3:0] fall, input logic pr);
      req_type t;
      t.user_present = u;
      t.imu_init_ok = imu;
      t.battery_level = batt_type'(batt);
      t.data_read_ok = rd;
      t.fall_direction = fall;
      t.pressure_ok = pr;
      return t;
   endfunction

   function automatic rsp_type want_of(input mode_type m, input logic u, input logic f,
                                       input logic full, input logic inf, input logic def,
                                       input logic shut);
      rsp_type s;
      s.mode = m;
      s.user_led = u;
      s.fall_led = f;
      s.inflated_led = full;
      s.inflate_pulse = inf;
      s.deflate_pulse = def;
      s.shutdown_pulse = shut;
      s.error_lights = (m == MODE_IMUERR) || (m == MODE_INFERR);
      return s;
   endfunction

   function automatic string status_text(input rsp_type s);
      return $sformatf("mode=%0d leds(user=%0b fall=%0b full=%0b) inflate=%0b deflate=%0b shutdown=%0b err=%0b",
                       s.mode, s.user_led, s.fall_led, s.inflated_led, s.inflate_pulse,
                       s.deflate_pulse, s.shutdown_pulse, s.error_lights);
   endfunction

   // One millisecond tick of the mode sequencer: advance the shadow state and
   // return the status beat the block must emit for it.
   function automatic rsp_type step_sequencer(input req_type t);
      rsp_type r;
      logic    batt_low;
      logic    inflate_p;
      logic    deflate_p;
      logic    shutdown_p;
      batt_low = t.battery_level < cfg.battery_low_threshold;
      inflate_p = 1'b0;
      deflate_p = 1'b0;
      shutdown_p = 1'b0;

      // Both counters advance every tick and stick at all ones.
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      if (since_read != '1) since_read = since_read + 1'b1;

      case (cur_mode)
         MODE_START: cur_mode = MODE_USER;
         MODE_USER: begin
            if (t.user_present) begin
               led_user = 1'b1;
               if (!t.imu_init_ok) begin
                  cur_mode = MODE_IMUERR;
                  elapsed = '0;
               end else begin
                  cur_mode = MODE_BATT;
               end
            end
         end
         MODE_BATT: begin
            if (batt_low) begin
               cur_mode = MODE_LOWBAT;
            end else begin
               cur_mode = MODE_CAL;
               elapsed = '0;
            end
         end
         // Inverted on purpose: only a low sample gets out of low battery.
         MODE_LOWBAT: begin
            if (batt_low) begin
               shutdown_p = 1'b1;
               cur_mode = MODE_START;
            end
         end
         MODE_CAL: begin
            if (!t.user_present) begin
               led_user = 1'b0;
               shutdown_p = 1'b1;
               cur_mode = MODE_START;
            end else if (batt_low) begin
               cur_mode = MODE_LOWBAT;
            end else if (32'(elapsed) >= 32'(cfg.calibration_ticks)) begin
               cur_mode = MODE_DETECT;
            end
         end
         MODE_DETECT: begin
            if (!t.user_present) begin
               led_user = 1'b0;
               shutdown_p = 1'b1;
               cur_mode = MODE_START;
            end else if (batt_low) begin
               cur_mode = MODE_LOWBAT;
            end else if (!t.data_read_ok) begin
               if (32'(since_read) >= 32'(cfg.read_timeout_ticks)) begin
                  cur_mode = MODE_IMUERR;
                  elapsed = '0;
               end
            end else begin
               since_read = '0;
               if (t.fall_direction != '0) begin
                  led_fall = 1'b1;
                  inflate_p = 1'b1;
                  cur_mode = MODE_INFLATE;
                  elapsed = '0;
               end
            end
         end
         MODE_IMUERR, MODE_INFERR: begin
            if (32'(elapsed) >= 32'(cfg.error_ticks)) begin
               shutdown_p = 1'b1;
               elapsed = '0;
            end
         end
         MODE_INFLATE: begin
            if (32'(elapsed) >= 32'(cfg.inflate_ticks)) begin
               led_fall = 1'b0;
               led_full = 1'b1;
               elapsed = '0;
               cur_mode = MODE_HOLD;
            end
         end
         MODE_HOLD: begin
            if (!t.pressure_ok) begin
               cur_mode = MODE_INFERR;
               elapsed = '0;
            end else if (32'(elapsed) >= 32'(cfg.hold_ticks)) begin
               led_full = 1'b0;
               elapsed = '0;
               cur_mode = MODE_DEFLATE;
            end
         end
         // Deflate leaves the timer running, so calibration counts from here.
         MODE_DEFLATE: begin
            deflate_p = 1'b1;
            cur_mode = MODE_CAL;
         end
         default: cur_mode = MODE_START;
      endcase

      r = want_of(cur_mode, led_user, led_fall, led_full, inflate_p, deflate_p, shutdown_p);
      return r;
   endfunction

   // Random tick shaped by the shadow state: mostly a wearer with a good
   // battery, so the sequence gets past the checks into calibration, fall
   // watch and inflation. Guards keep the error traps shut until the last phase.
   function automatic req_type make_tick(input logic [2:0] guard);
      req_type     t;
      int unsigned r;
      int unsigned thr;
      thr = cfg.battery_low_threshold;
      t.user_present = ($urandom_range(0, 99) < 94);
      t.imu_init_ok = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 5) t.battery_level = '0;
      else if (r < 12) t.battery_level = batt_type'($urandom);
      else if (r < 16) t.battery_level = '1;
      else if (r < 19) t.battery_level = batt_type'(thr);
      else if (r < 22 && thr != 0) t.battery_level = batt_type'(thr - 1);
      else t.battery_level = batt_type'($urandom_range(thr, 1023));
      t.data_read_ok = ($urandom_range(0, 99) < 80);
      t.fall_direction = ($urandom_range(0, 99) < 12) ? 4'($urandom_range(1, 15)) : 4'd0;
      t.pressure_ok = ($urandom_range(0, 99) < 75);

      if (guard[GuardImu] && cur_mode == MODE_USER && t.user_present) t.imu_init_ok = 1'b1;
      if (guard[GuardRead] && cur_mode == MODE_DETECT &&
          32'(since_read) + 1 >= 32'(cfg.read_timeout_ticks)) t.data_read_ok = 1'b1;
      if (guard[GuardPress] && cur_mode == MODE_HOLD) t.pressure_ok = 1'b1;
      return t;
   endfunction

   function automatic cfg_type random_timings(input int unsigned hi);
      cfg_type c;
      c.calibration_ticks = cfg_tick_type'($urandom_range(1, hi));
      c.read_timeout_ticks = cfg_tick_type'($urandom_range(1, hi));
      c.inflate_ticks = cfg_tick_type'($urandom_range(1, hi));
      c.hold_ticks = cfg_tick_type'($urandom_range(1, hi));
      c.error_ticks = cfg_tick_type'($urandom_range(1, hi));
      c.battery_low_threshold = batt_type'($urandom_range(0, 1023));
      return c;
   endfunction

   // Launch one tick beat: idle first if asked, then hold valid and payload
   // until the beat is taken. With no gap, valid simply stays high.
   task automatic send_tick(input req_type t, input rsp_type want, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      pending_status <= want;
      ticks_launched++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every launched tick has come back as status.
   task automatic settle();
      req_valid <= 1'b0;
      while (status_seen < ticks_launched) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexBits-1:0] idx,
                            input logic [CsrDataBits-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CALIBRATION:  cfg.calibration_ticks = value;
         CSR_READ_TIMEOUT: cfg.read_timeout_ticks = value;
         CSR_INFLATE:      cfg.inflate_ticks = value;
         CSR_HOLD:         cfg.hold_ticks = value;
         CSR_ERROR:        cfg.error_ticks = value;
         CSR_BATT_LOW:     cfg.battery_low_threshold = value[BattBits-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Write every register, junk in the threshold's unused upper bits, then
   // hit both spare slots with random data that must not land anywhere.
   task automatic load_config(input cfg_type c);
      write_reg(CSR_CALIBRATION, c.calibration_ticks);
      write_reg(CSR_READ_TIMEOUT, c.read_timeout_ticks);
      write_reg(CSR_INFLATE, c.inflate_ticks);
      write_reg(CSR_HOLD, c.hold_ticks);
      write_reg(CSR_ERROR, c.error_ticks);
      write_reg(CSR_BATT_LOW, {(CsrDataBits - BattBits)'($urandom), c.battery_low_threshold});
      write_reg(CsrSpareLo, CsrDataBits'($urandom));
      write_reg(CsrSpareHi, CsrDataBits'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Receiver: random stalls, with steady stretches where it never stalls.
   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rx_hold <= pick_gap(rx_steady);
      end
      if ($urandom_range(0, 99) < 2) rx_steady <= !rx_steady;
   end

   // Scoreboard: check each status beat against the oldest expectation, then
   // queue the expectation of any tick beat taken at this edge. Both in one
   // process so a push never races a pop.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("status beat %0d with nothing expected: %s",
                           status_seen, status_text(rsp_data));
            end else begin
               oldest_status = expected_status.pop_front();
               if (rsp_data !== oldest_status) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("status beat %0d mismatch\n  expected %s\n  actual   %s",
                              status_seen, status_text(oldest_status), status_text(rsp_data));
               end
            end
            status_seen++;
         end
         if (req_valid && req_ready) expected_status.push_back(pending_status);
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      cfg_type     timings;
      cfg_type     short_timings;
      req_type     t;
      rsp_type     want;
      rsp_type     predicted;
      logic [2:0]  guard;
      int          phase_len;
      bit          tx_steady;

      tx_steady = 1'b0;

      // Shadow starts from the reset values.
      cfg.calibration_ticks = CalibrationReset;
      cfg.read_timeout_ticks = ReadTimeoutReset;
      cfg.inflate_ticks = InflateReset;
      cfg.hold_ticks = HoldReset;
      cfg.error_ticks = ErrorReset;
      cfg.battery_low_threshold = BattLowReset;
      cur_mode = MODE_START;
      elapsed = '0;
      since_read = '0;
      led_user = 1'b0;
      led_fall = 1'b0;
      led_full = 1'b0;

      // Short timings so the directed walk reaches every non-error mode in a few ticks.
      short_timings.calibration_ticks = 16'd2;
      short_timings.read_timeout_ticks = 16'd3;
      short_timings.inflate_ticks = 16'd2;
      short_timings.hold_ticks = 16'd2;
      short_timings.error_ticks = 16'd2;
      short_timings.battery_low_threshold = 10'd512;

      // Directed walk. The first rows run on reset register values, so the
      // low-battery threshold of 512 is checked right at its edge.
      //                        cfg        check    status                              tick: user imu batt rd fall pr
      dir_rows[0]  = '{KeepCfg,   Typed,   want_of(MODE_USER,    0, 0, 0, 0, 0, 0), tick_of(0, 0,    0, 0, 4'h0, 0)};
      dir_rows[1]  = '{KeepCfg,   Typed,   want_of(MODE_USER,    0, 0, 0, 0, 0, 0), tick_of(0, 1, 1023, 1, 4'hF, 1)};
      dir_rows[2]  = '{KeepCfg,   Typed,   want_of(MODE_BATT,    1, 0, 0, 0, 0, 0), tick_of(1, 1, 1023, 0, 4'h0, 0)};
      // One below the threshold is low.
      dir_rows[3]  = '{KeepCfg,   Typed,   want_of(MODE_LOWBAT,  1, 0, 0, 0, 0, 0), tick_of(1, 1,  511, 0, 4'h0, 0)};
      // Inverted low-battery test: a full sample keeps the block in low battery.
      dir_rows[4]  = '{KeepCfg,   Typed,   want_of(MODE_LOWBAT,  1, 0, 0, 0, 0, 0), tick_of(1, 1, 1023, 1, 4'h0, 1)};
      dir_rows[5]  = '{KeepCfg,   Typed,   want_of(MODE_START,   1, 0, 0, 0, 0, 1), tick_of(1, 1,    0, 0, 4'h0, 0)};
      dir_rows[6]  = '{KeepCfg,   Typed,   want_of(MODE_USER,    1, 0, 0, 0, 0, 0), tick_of(1, 0, 1023, 0, 4'h0, 0)};
      dir_rows[7]  = '{KeepCfg,   Typed,   want_of(MODE_BATT,    1, 0, 0, 0, 0, 0), tick_of(1, 1, 1023, 0, 4'h0, 0)};
      // Exactly at the threshold is not low.
      dir_rows[8]  = '{KeepCfg,   Typed,   want_of(MODE_CAL,     1, 0, 0, 0, 0, 0), tick_of(1, 1,  512, 1, 4'h0, 1)};
      // Calibration, fall watch, inflate, hold, deflate on the short timings.
      dir_rows[9]  = '{LoadShort, Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 1, 4'h0, 1)};
      dir_rows[10] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 1, 4'h0, 1)};
      dir_rows[11] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 1, 4'h0, 1)};
      dir_rows[12] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 0, 4'h0, 1)};
      dir_rows[13] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 1, 4'h1, 1)};
      dir_rows[14] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 0,    0, 0, 4'h0, 0)};
      dir_rows[15] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 0,    0, 0, 4'h0, 0)};
      dir_rows[16] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 0, 4'hF, 1)};
      dir_rows[17] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 0, 4'hF, 1)};
      dir_rows[18] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(0, 0,    0, 0, 4'h0, 0)};
      // Deflate did not clear the timer, so calibration ends on the next tick.
      dir_rows[19] = '{KeepCfg,   Predict, rsp_type'('0),                           tick_of(1, 1, 1023, 1, 4'h0, 1)};
      // Wearer lost beats low battery and a fall in the same tick.
      dir_rows[20] = '{KeepCfg,   Typed,   want_of(MODE_START,   0, 0, 0, 0, 0, 1), tick_of(0, 1,    0, 1, 4'h8, 1)};
      dir_rows[21] = '{KeepCfg,   Typed,   want_of(MODE_USER,    0, 0, 0, 0, 0, 0), tick_of(1, 1, 1023, 1, 4'h0, 1)};
      dir_rows[22] = '{KeepCfg,   Typed,   want_of(MODE_BATT,    1, 0, 0, 0, 0, 0), tick_of(1, 1, 1023, 1, 4'h0, 1)};
      dir_rows[23] = '{KeepCfg,   Typed,   want_of(MODE_CAL,     1, 0, 0, 0, 0, 0), tick_of(1, 1, 1023, 1, 4'h0, 1)};
      // Wearer lost during calibration.
      dir_rows[24] = '{KeepCfg,   Typed,   want_of(MODE_START,   0, 0, 0, 0, 0, 1), tick_of(0, 1, 1023, 1, 4'h0, 1)};

      // Hold reset from time zero, then release it for good.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirCount; i++) begin
         if (dir_rows[i].load_short) begin
            settle();
            load_config(short_timings);
         end
         predicted = step_sequencer(dir_rows[i].tick);
         want = dir_rows[i].typed ? dir_rows[i].want : predicted;
         send_tick(dir_rows[i].tick, want, pick_gap(tx_steady));
      end

      // Random phases, each on its own register setting. Both error modes
      // are traps that only reset leaves, so the error routes stay guarded
      // until the last phase, which opens one of them at random.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         case (phase)
            0: begin
               timings = random_timings(1);
               timings.battery_low_threshold = '0;
               phase_len = 150;
            end
            1: begin
               timings = random_timings(6);
               timings.calibration_ticks = cfg_tick_type'($urandom_range(1, 12));
               phase_len = 200;
            end
            2: begin
               timings = random_timings(5);
               timings.battery_low_threshold = '1;
               phase_len = 150;
            end
            3: begin
               timings = random_timings(1);
               timings.calibration_ticks = '1;
               timings.read_timeout_ticks = '1;
               timings.inflate_ticks = '1;
               timings.hold_ticks = '1;
               timings.error_ticks = '1;
               phase_len = 60;
            end
            4: begin
               timings = random_timings(8);
               phase_len = 250;
            end
            default: begin
               timings = random_timings(4);
               phase_len = 140;
            end
         endcase
         load_config(timings);

         guard = GuardAll;
         if (phase == PhaseCount - 1) guard[$urandom_range(0, 2)] = 1'b0;

         for (int n = 0; n < phase_len; n++) begin
            t = make_tick(guard);
            want = step_sequencer(t);
            if ($urandom_range(0, 99) < 3) tx_steady = !tx_steady;
            send_tick(t, want, pick_gap(tx_steady));
         end
      end

      // Drain, then wait out the settle time so any stray beat can show.
      settle();
      if (expected_status.size() != 0) begin
         fault_count += expected_status.size();
         $display("%0d expected status beats never arrived", expected_status.size());
      end

      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
